// ----- design/trie_pkg.sv -----
// Package for the prefix trie: sizes, memory row and request types, controller states.
// Used by the channel interfaces, the controller and the top level; depends on nothing.
package trie_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int ALPHABET   = 26;
  localparam int ID_W       = $clog2(MAX_NODES);
  localparam int CNT_W      = ID_W + 1;
  localparam int LETTER_W   = 5;
  localparam int ROW_W      = ALPHABET + 1;
  localparam int LINK_DEPTH = MAX_NODES * ALPHABET;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int WORD_END   = ALPHABET;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [LINK_AW-1:0] link_addr_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_CLEAR,
    ST_FREAD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic we;
    id_t  waddr;
    row_t wdata;
    id_t  raddr;
  } node_port_t;

  typedef struct packed {
    logic       we;
    link_addr_t waddr;
    id_t        wdata;
    link_addr_t raddr;
  } link_port_t;

  function automatic link_addr_t link_addr(input id_t node, input letter_t letter);
    link_addr_t base;
    base = LINK_AW'(node) * LINK_AW'(ALPHABET);
    return base + LINK_AW'(letter);
  endfunction

endpackage

// ----- design/trie_item_if.sv -----
// Input channel of the trie: one letter of a word per transfer.
// Depends on trie_pkg.
interface trie_item_if;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  trie_pkg::letter_t     letter;
  logic                  last;
  logic                  empty_word;

  modport source (output valid, mode, letter, last, empty_word, input ready);
  modport sink (input valid, mode, letter, last, empty_word, output ready);
endinterface

// ----- design/trie_result_if.sv -----
// Output channel of the trie: one result per finished word.
// Depends on trie_pkg.
interface trie_result_if;
  logic          valid;
  logic          ready;
  trie_pkg::id_t node_id;
  logic          found;
  logic          store_full;

  modport source (output valid, node_id, found, store_full, input ready);
  modport sink (input valid, node_id, found, store_full, output ready);
endinterface

// ----- design/trie_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module trie_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/trie_ctrl.sv -----
// Trie sequencer: walks, allocates and marks nodes through the node and link memories,
// and holds the result register. Depends on trie_pkg, trie_item_if and trie_result_if.
module trie_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  trie_item_if.sink               item,
  trie_result_if.source           result,
  output trie_pkg::node_port_t    node_req,
  input  trie_pkg::row_t          node_rdata,
  output trie_pkg::link_port_t    link_req,
  input  trie_pkg::id_t           link_rdata
);

  trie_pkg::state_t  state, state_next;
  trie_pkg::id_t     cursor, cursor_next;
  trie_pkg::count_t  node_count, node_count_next;
  logic              path_broken, path_broken_next;
  logic              overflowed, overflowed_next;
  logic              mode, mode_next;
  trie_pkg::letter_t letter, letter_next;
  logic              last, last_next;
  logic              out_valid, out_valid_next;
  trie_pkg::id_t     out_id, out_id_next;
  logic              out_found, out_found_next;
  logic              out_full, out_full_next;

  logic accept;
  logic out_free;
  logic item_letter_ok;
  logic present;
  logic store_full_now;

  assign accept         = item.valid && item.ready;
  assign out_free       = !out_valid || result.ready;
  assign item_letter_ok = item.letter < trie_pkg::LETTER_W'(trie_pkg::ALPHABET);
  assign present        = node_rdata[letter];
  assign store_full_now = node_count >= trie_pkg::CNT_W'(trie_pkg::MAX_NODES);

  assign item.ready        = state == trie_pkg::ST_IDLE;
  assign result.valid      = out_valid;
  assign result.node_id    = out_id;
  assign result.found      = out_found;
  assign result.store_full = out_full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      trie_pkg::ST_INIT: begin
        state_next = trie_pkg::ST_IDLE;
      end
      trie_pkg::ST_IDLE: begin
        if (accept) begin
          if (item.empty_word) begin
            state_next = trie_pkg::ST_FREAD;
          end else if (path_broken || overflowed || !item_letter_ok) begin
            if (item.last) begin
              state_next = trie_pkg::ST_FINISH;
            end
          end else begin
            state_next = trie_pkg::ST_WALK;
          end
        end
      end
      trie_pkg::ST_WALK: begin
        if (present) begin
          state_next = last ? trie_pkg::ST_FREAD : trie_pkg::ST_IDLE;
        end else if (mode == trie_pkg::MODE_LOOKUP || store_full_now) begin
          state_next = last ? trie_pkg::ST_FINISH : trie_pkg::ST_IDLE;
        end else begin
          state_next = trie_pkg::ST_CLEAR;
        end
      end
      trie_pkg::ST_CLEAR: begin
        if (!last || out_free) begin
          state_next = trie_pkg::ST_IDLE;
        end
      end
      trie_pkg::ST_FREAD: begin
        state_next = trie_pkg::ST_FINISH;
      end
      trie_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = trie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = trie_pkg::ST_INIT;
      end
    endcase
  end

  // datapath and memory requests
  always_comb begin
    cursor_next      = cursor;
    node_count_next  = node_count;
    path_broken_next = path_broken;
    overflowed_next  = overflowed;
    mode_next        = mode;
    letter_next      = letter;
    last_next        = last;
    out_valid_next   = out_valid && !result.ready;
    out_id_next      = out_id;
    out_found_next   = out_found;
    out_full_next    = out_full;

    node_req.we    = 1'b0;
    node_req.waddr = cursor;
    node_req.wdata = '0;
    node_req.raddr = cursor;
    link_req.we    = 1'b0;
    link_req.waddr = trie_pkg::link_addr(cursor, letter);
    link_req.wdata = node_count[trie_pkg::ID_W-1:0];
    link_req.raddr = trie_pkg::link_addr(cursor, item_letter_ok ? item.letter : '0);

    case (state)
      trie_pkg::ST_INIT: begin
        node_req.we = 1'b1;
      end
      trie_pkg::ST_IDLE: begin
        if (accept) begin
          mode_next   = item.mode;
          letter_next = item.letter;
          last_next   = item.last;
          if (item.empty_word) begin
            cursor_next      = '0;
            path_broken_next = 1'b0;
            overflowed_next  = 1'b0;
          end else if (!path_broken && !overflowed && !item_letter_ok) begin
            path_broken_next = 1'b1;
          end
        end
      end
      trie_pkg::ST_WALK: begin
        if (present) begin
          cursor_next = link_rdata;
        end else if (mode == trie_pkg::MODE_LOOKUP) begin
          path_broken_next = 1'b1;
        end else if (store_full_now) begin
          overflowed_next = 1'b1;
        end else begin
          node_req.we     = 1'b1;
          node_req.wdata  = node_rdata | (trie_pkg::ROW_W'(1) << letter);
          link_req.we     = 1'b1;
          cursor_next     = node_count[trie_pkg::ID_W-1:0];
          node_count_next = node_count + 1'b1;
        end
      end
      trie_pkg::ST_CLEAR: begin
        node_req.we                       = 1'b1;
        node_req.wdata[trie_pkg::WORD_END] = last;
        if (last && out_free) begin
          out_valid_next = 1'b1;
          out_id_next    = cursor;
          out_found_next = 1'b1;
          out_full_next  = 1'b0;
          cursor_next    = '0;
        end
      end
      trie_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_full_next    = overflowed;
          out_id_next      = '0;
          out_found_next   = 1'b0;
          cursor_next      = '0;
          path_broken_next = 1'b0;
          overflowed_next  = 1'b0;
          if (!path_broken && !overflowed) begin
            if (mode == trie_pkg::MODE_INSERT) begin
              node_req.we                       = 1'b1;
              node_req.wdata                    = node_rdata;
              node_req.wdata[trie_pkg::WORD_END] = 1'b1;
              out_found_next                    = 1'b1;
              out_id_next                       = cursor;
            end else if (node_rdata[trie_pkg::WORD_END]) begin
              out_found_next = 1'b1;
              out_id_next    = cursor;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= trie_pkg::ST_INIT;
      cursor      <= '0;
      node_count  <= trie_pkg::CNT_W'(1);
      path_broken <= 1'b0;
      overflowed  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cursor      <= cursor_next;
      node_count  <= node_count_next;
      path_broken <= path_broken_next;
      overflowed  <= overflowed_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mode      <= mode_next;
    letter    <= letter_next;
    last      <= last_next;
    out_id    <= out_id_next;
    out_found <= out_found_next;
    out_full  <= out_full_next;
  end

endmodule

// ----- design/trie_insert_lookup.sv -----
// Prefix trie over a 26-letter alphabet with insert and lookup of words, one letter
// per transfer on item; one result per finished word on result.
// Depends on trie_pkg, trie_item_if, trie_result_if, trie_ram and trie_ctrl.
//
// item carries mode (0 insert, 1 lookup), letter, last and empty_word. A transfer
// with last or empty_word ends the word and yields one transfer on result with
// node_id, found and store_full; other transfers yield nothing.
// Nodes live in a row memory (26 child-present bits and a word-end bit per node) and
// a link memory (child identifiers, node times letter), both with a registered read
// and updated by read-modify-write from a single sequencer.
// Steps per item: a letter that follows or misses a link passes IDLE and WALK, one that
// allocates a node passes IDLE, WALK and CLEAR (parent row update, then the new row is
// cleared with its word-end mark), and a letter that is out of range or belongs to a
// broken or overflowed word is dropped in IDLE. A final letter that misses or is dropped
// adds FINISH, a final letter that follows a link passes IDLE, WALK, FREAD and FINISH and
// an empty word IDLE, FREAD and FINISH, since the end node's row is read before it is
// marked or tested. Reset is synchronous; the INIT state clears the root row after
// reset, before item is ready. The result sits in an output register: a stalled
// receiver holds it, and further letters are taken until the next word end, which waits.
module trie_insert_lookup (
  input  logic          clk,
  input  logic          rst,
  trie_item_if.sink     item,
  trie_result_if.source result
);

  trie_pkg::node_port_t node_req;
  trie_pkg::link_port_t link_req;
  trie_pkg::row_t       node_rdata;
  trie_pkg::id_t        link_rdata;

  trie_ram #(
    .DEPTH (trie_pkg::MAX_NODES),
    .WIDTH (trie_pkg::ROW_W)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_req.we),
    .waddr (node_req.waddr),
    .wdata (node_req.wdata),
    .raddr (node_req.raddr),
    .rdata (node_rdata)
  );

  trie_ram #(
    .DEPTH (trie_pkg::LINK_DEPTH),
    .WIDTH (trie_pkg::ID_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  trie_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .result     (result),
    .node_req   (node_req),
    .node_rdata (node_rdata),
    .link_req   (link_req),
    .link_rdata (link_rdata)
  );

  a_link_with_row: assert property (@(posedge clk) disable iff (rst)
    link_req.we |-> node_req.we)
    else $error("link written without parent row update");

  a_clear_after_alloc: assert property (@(posedge clk) disable iff (rst)
    link_req.we |=> (node_req.we && !link_req.we))
    else $error("new node row not cleared after allocation");

  a_found_not_full: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.found) |-> !result.store_full)
    else $error("result both found and store full");

  a_miss_zero_id: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |-> (result.node_id == '0))
    else $error("nonzero node id on a miss");

endmodule
